@@ rtl/bdhd_pkg.sv @@
// Shared types and constants for the button debounce and hold detector.
// No dependencies; every other file of the block depends on this package.
package bdhd_pkg;

   // Default timestamp width in bits.
   localparam int TIME_BITS_DEFAULT = 32;

   // Widths of the configuration fields.
   localparam int HOLD_BITS     = 26;
   localparam int DEBOUNCE_BITS = 20;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE       = 2'd2;

   // Reset values of the configuration registers.
   localparam logic                     ACTIVE_RESET   = 1'b0;
   localparam logic [HOLD_BITS-1:0]     HOLD_RESET     = 26'd1000000;
   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 20'd5000;

   // Item kinds carried in the mode field.
   localparam logic MODE_EDGE = 1'b0;
   localparam logic MODE_POLL = 1'b1;

   // Current configuration, from the register block to the core.
   typedef struct packed {
      logic                     active_level;
      logic [HOLD_BITS-1:0]     hold_threshold_us;
      logic [DEBOUNCE_BITS-1:0] debounce_us;
   } cfg_type;

   // Result flags of one item.
   typedef struct packed {
      logic press_event;
      logic release_event;
      logic hold_event;
      logic is_pressed;
   } evt_type;

endpackage

@@ rtl/bdhd_if.sv @@
// Channel interfaces of the button debounce and hold detector.
// Depends on bdhd_pkg for widths.

// Input items: edge reports and poll ticks.
interface bdhd_req_if #(
   parameter int TIME_BITS = bdhd_pkg::TIME_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [TIME_BITS-1:0] now_us;
   logic                 pin_level;

   modport source (output valid, output mode, output now_us, output pin_level, input ready);
   modport sink   (input valid, input mode, input now_us, input pin_level, output ready);
endinterface

// Result items.
interface bdhd_rsp_if;
   logic valid;
   logic ready;
   logic press_event;
   logic release_event;
   logic hold_event;
   logic is_pressed;

   modport source (output valid, output press_event, output release_event,
                   output hold_event, output is_pressed, input ready);
   modport sink   (input valid, input press_event, input release_event,
                   input hold_event, input is_pressed, output ready);
endinterface

// Configuration register writes.
interface bdhd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bdhd_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic [bdhd_pkg::CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/bdhd_csr.sv @@
// Configuration registers of the button debounce and hold detector.
// Depends on bdhd_pkg and the bdhd_csr_if interface.
module bdhd_csr (
   input  logic              clock,
   input  logic              reset,
   bdhd_csr_if.sink          csr_chan,
   output bdhd_pkg::cfg_type cfg
);
   import bdhd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   // Writes are always taken.
   assign csr_chan.ready = 1'b1;
   assign write_en       = csr_chan.valid;

   // Register decode; writes to an unlisted index are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_chan.reg_index)
            CSR_ACTIVE_LEVEL: begin
               cfg_in.active_level = csr_chan.wdata[0];
            end
            CSR_HOLD_THRESHOLD: begin
               cfg_in.hold_threshold_us = csr_chan.wdata[HOLD_BITS-1:0];
            end
            CSR_DEBOUNCE: begin
               cfg_in.debounce_us = csr_chan.wdata[DEBOUNCE_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level      <= ACTIVE_RESET;
         cfg_ff.hold_threshold_us <= HOLD_RESET;
         cfg_ff.debounce_us       <= DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/bdhd_core.sv @@
// Debounce and hold state with the single-pass next-state logic for one item.
// Depends on bdhd_pkg.
module bdhd_core #(
   parameter int TIME_BITS = bdhd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 mode,
   input  logic [TIME_BITS-1:0] now_us,
   input  logic                 pin_level,
   input  bdhd_pkg::cfg_type    cfg,
   output bdhd_pkg::evt_type    evt
);
   import bdhd_pkg::*;

   localparam int SUM_BITS = (TIME_BITS > DEBOUNCE_BITS) ? TIME_BITS : DEBOUNCE_BITS;
   localparam int CMP_BITS = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;

   logic                 pressed_state_ff, pressed_state_in;
   logic                 hold_armed_ff, hold_armed_in;
   logic                 release_suppress_ff, release_suppress_in;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic                 edge_pending_ff, edge_pending_in;
   logic                 pending_level_ff, pending_level_in;
   logic [TIME_BITS-1:0] apply_deadline_ff, apply_deadline_in;

   logic                 level_active;
   logic [SUM_BITS-1:0]  deadline_sum;
   logic [TIME_BITS-1:0] deadline_diff;
   logic                 deadline_due;
   logic [TIME_BITS-1:0] hold_elapsed;

   // Pin level in pressed terms, and the new deadline for an edge.
   assign level_active  = (pin_level == cfg.active_level);
   assign deadline_sum  = SUM_BITS'(now_us) + SUM_BITS'(cfg.debounce_us);
   assign deadline_diff = now_us - apply_deadline_ff;
   assign deadline_due  = edge_pending_ff && !deadline_diff[TIME_BITS-1];

   // Edge capture, then confirmation, then hold detection for a poll.
   always_comb begin
      pressed_state_in    = pressed_state_ff;
      hold_armed_in       = hold_armed_ff;
      release_suppress_in = release_suppress_ff;
      press_time_in       = press_time_ff;
      edge_pending_in     = edge_pending_ff;
      pending_level_in    = pending_level_ff;
      apply_deadline_in   = apply_deadline_ff;
      hold_elapsed        = '0;
      evt                 = '0;

      if (mode == MODE_EDGE) begin
         pending_level_in  = level_active;
         apply_deadline_in = deadline_sum[TIME_BITS-1:0];
         edge_pending_in   = 1'b1;
      end else begin
         // Confirm the pending level once its deadline has passed.
         if (deadline_due) begin
            if (level_active == pending_level_ff) begin
               if (level_active && !pressed_state_ff) begin
                  pressed_state_in    = 1'b1;
                  evt.press_event     = 1'b1;
                  hold_armed_in       = 1'b0;
                  release_suppress_in = 1'b0;
                  press_time_in       = now_us;
               end else if (!level_active && pressed_state_ff) begin
                  pressed_state_in = 1'b0;
                  hold_armed_in    = 1'b0;
                  if (release_suppress_ff) begin
                     release_suppress_in = 1'b0;
                  end else begin
                     evt.release_event = 1'b1;
                  end
               end
            end
            edge_pending_in = 1'b0;
         end

         // Fire hold once per press after the threshold.
         hold_elapsed = now_us - press_time_in;
         if (pressed_state_in && !hold_armed_in) begin
            if (CMP_BITS'(hold_elapsed) >= CMP_BITS'(cfg.hold_threshold_us)) begin
               evt.hold_event      = 1'b1;
               hold_armed_in       = 1'b1;
               release_suppress_in = 1'b1;
            end
         end
      end

      evt.is_pressed = pressed_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_state_ff    <= 1'b0;
         hold_armed_ff       <= 1'b0;
         release_suppress_ff <= 1'b0;
         press_time_ff       <= '0;
         edge_pending_ff     <= 1'b0;
         pending_level_ff    <= 1'b0;
         apply_deadline_ff   <= '0;
      end else if (step) begin
         pressed_state_ff    <= pressed_state_in;
         hold_armed_ff       <= hold_armed_in;
         release_suppress_ff <= release_suppress_in;
         press_time_ff       <= press_time_in;
         edge_pending_ff     <= edge_pending_in;
         pending_level_ff    <= pending_level_in;
         apply_deadline_ff   <= apply_deadline_in;
      end
   end

`ifndef SYNTHESIS
   // A hold can only be armed while the button is held down.
   a_hold_needs_press: assert property (@(posedge clock) disable iff (reset)
      hold_armed_ff |-> pressed_state_ff)
      else $error("hold armed while released");

   // Release suppression is set and cleared together with the hold flag.
   a_suppress_tracks_hold: assert property (@(posedge clock) disable iff (reset)
      release_suppress_ff == hold_armed_ff)
      else $error("release suppression out of step with hold");

   // An edge transaction never changes the debounced state.
   a_edge_keeps_state: assert property (@(posedge clock) disable iff (reset)
      step && (mode == MODE_EDGE) |=> $stable(pressed_state_ff))
      else $error("edge item changed the debounced state");

   // A confirmed press leaves the button pressed.
   a_press_sets_state: assert property (@(posedge clock) disable iff (reset)
      step && evt.press_event |=> pressed_state_ff)
      else $error("press event without pressed state");
`endif

endmodule

@@ rtl/button_debounce_hold_detector.sv @@
// Button debouncer with press, release and long-press detection. It accepts one
// transaction per clock cycle while results are taken, and returns one result
// for each: the transaction is held in the input register, then makes a single
// pass through the core logic into the result register. When the result is not
// taken, one more transaction is held in the input register before the request
// side stalls. Configuration writes are taken in every cycle; they must only be
// issued while no transaction is in flight.
module button_debounce_hold_detector #(
   parameter int TIME_BITS = bdhd_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bdhd_req_if.sink    req_chan,
   bdhd_rsp_if.source  rsp_chan,
   bdhd_csr_if.sink    csr_chan
);
   import bdhd_pkg::*;

   cfg_type              cfg;
   evt_type              core_evt;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_mode_ff;
   logic [TIME_BITS-1:0] s1_now_ff;
   logic                 s1_pin_ff;
   logic                 out_valid_ff, out_valid_in;
   evt_type              out_evt_ff;

   logic                 advance;
   logic                 req_accept;
   logic                 step;

   // Pipeline flow control.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign step           = advance && s1_valid_ff;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   // Configuration registers.
   bdhd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Debounce and hold state.
   bdhd_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .mode      (s1_mode_ff),
      .now_us    (s1_now_ff),
      .pin_level (s1_pin_ff),
      .cfg       (cfg),
      .evt       (core_evt)
   );

   // Input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         s1_mode_ff <= req_chan.mode;
         s1_now_ff  <= req_chan.now_us;
         s1_pin_ff  <= req_chan.pin_level;
      end
      if (step) begin
         out_evt_ff <= core_evt;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.press_event   = out_evt_ff.press_event;
   assign rsp_chan.release_event = out_evt_ff.release_event;
   assign rsp_chan.hold_event    = out_evt_ff.hold_event;
   assign rsp_chan.is_pressed    = out_evt_ff.is_pressed;

`ifndef SYNTHESIS
   // With both stages full and the result not taken, no new transaction enters.
   a_full_stalls_req: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted into a full pipeline");

   // A waiting input item moves into the result register when it frees up.
   a_item_moves_on: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> out_valid_ff)
      else $error("item lost between stages");

   // A result that is not taken stays valid and unchanged.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(out_evt_ff))
      else $error("waiting result changed before it was taken");
`endif

endmodule
